// ===== rtl/core/rk2_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rk2_pkg: shared types and constants for the RK2 oscillator step
// Holds the controller command and status structs, state codes and
// register indexes used by the controller, datapath and top level.
// ----------------------------------------------------------------------------
package rk2_pkg;

  localparam int FracBits = 24;

  typedef enum logic [2:0] {
    REG_OMEGA_SQ  = 3'd0,
    REG_TIME_STEP = 3'd1,
    REG_ORDER     = 3'd2,
    REG_POT_COEFF = 3'd3,
    REG_HALF_MASS = 3'd4
  } reg_index_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_X,
    OP_ODD_INIT_X,
    OP_ODD_MUL,
    OP_ACC_A,
    OP_XT,
    OP_XT_ADD,
    OP_VT,
    OP_VT_ADD,
    OP_SQ_XT,
    OP_ODD_INIT_XT,
    OP_ACC_AT,
    OP_NEWX,
    OP_NEWX_ADD,
    OP_NEWV,
    OP_NEWV_ADD,
    OP_SQ_E,
    OP_EVEN_INIT,
    OP_EVEN_MUL,
    OP_PE,
    OP_VSQ,
    OP_KE,
    OP_TE,
    OP_CLEAR
  } dp_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] order;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rk2_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rk2_datapath: shared Q8.24 multiplier, adder and state registers
// Executes one controller operation per cycle on a registered operand file.
// ----------------------------------------------------------------------------
module rk2_datapath
  import rk2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire dp_cmd_t     cmd,
  input  wire logic [31:0] load_position,
  input  wire logic [31:0] load_velocity,
  input  wire logic [30:0] omega_sq,
  input  wire logic [30:0] time_step,
  input  wire logic [30:0] potential_coeff,
  input  wire logic [30:0] half_mass,
  output logic [31:0]      position_out,
  output logic [31:0]      velocity_out,
  output logic [30:0]      potential_energy,
  output logic [30:0]      kinetic_energy,
  output logic [30:0]      total_energy,
  output logic             overflow
);

  localparam logic signed [63:0] RoundHalf = 64'sd1 <<< (FracBits - 1);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  logic signed [31:0] pos, vel, sq, acc, pw, tmp, xt, vt, at, pe, ke;
  logic               sat;
  logic signed [31:0] ma, mb, mres, aa, ab, ares;
  logic               msat, asat;
  logic signed [63:0] prod, rsum;
  logic signed [39:0] shifted;
  logic signed [32:0] asum;

  // Operand selection for the shared multiplier and adder.
  always_comb begin
    ma = pos;
    mb = pos;
    aa = pos;
    ab = tmp;
    case (cmd.op)
      OP_SQ_X:     begin ma = pos; mb = pos; end
      OP_ODD_MUL,
      OP_EVEN_MUL: begin ma = pw; mb = sq; end
      OP_ACC_A,
      OP_ACC_AT:   begin ma = $signed({1'b0, omega_sq}); mb = pw; end
      OP_XT:       begin ma = $signed({2'b0, time_step[30:1]}); mb = vel; end
      OP_VT:       begin ma = $signed({2'b0, time_step[30:1]}); mb = acc; end
      OP_SQ_XT:    begin ma = xt; mb = xt; end
      OP_NEWX:     begin ma = $signed({1'b0, time_step}); mb = vt; end
      OP_NEWV:     begin ma = $signed({1'b0, time_step}); mb = at; end
      OP_SQ_E:     begin ma = pos; mb = pos; end
      OP_PE:       begin ma = $signed({1'b0, potential_coeff}); mb = pw; end
      OP_VSQ:      begin ma = vel; mb = vel; end
      OP_KE:       begin ma = $signed({1'b0, half_mass}); mb = tmp; end
      default:     begin ma = pos; mb = pos; end
    endcase
    case (cmd.op)
      OP_XT_ADD:   begin aa = pos; ab = tmp; end
      OP_VT_ADD:   begin aa = vel; ab = tmp; end
      OP_NEWX_ADD: begin aa = pos; ab = tmp; end
      OP_NEWV_ADD: begin aa = vel; ab = tmp; end
      OP_TE:       begin aa = pe[31] ? 32'sd0 : pe; ab = ke[31] ? 32'sd0 : ke; end
      default:     begin aa = pos; ab = tmp; end
    endcase
  end

  // Rounded product and saturating sum.
  always_comb begin
    prod = 64'(ma) * 64'(mb);
    rsum = prod + RoundHalf;
    shifted = 40'(rsum >>> FracBits);
    msat = 1'b0;
    if (64'(shifted) > Max32) begin
      mres = 32'sh7fffffff;
      msat = 1'b1;
    end else if (64'(shifted) < Min32) begin
      mres = 32'sh80000000;
      msat = 1'b1;
    end else begin
      mres = shifted[31:0];
    end
    asum = 33'(aa) + 33'(ab);
    asat = asum[32] != asum[31];
    ares = asat ? (asum[32] ? 32'sh80000000 : 32'sh7fffffff) : asum[31:0];
  end

  // Negated acceleration saturates only for the most negative value.
  logic signed [31:0] neg;
  logic               nsat;
  always_comb begin
    nsat = mres == 32'sh80000000;
    neg = nsat ? 32'sh7fffffff : -mres;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      vel <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR:       sat <= 1'b0;
        OP_LOAD:        begin pos <= load_position; vel <= load_velocity; sat <= 1'b0; end
        OP_SQ_X,
        OP_SQ_XT,
        OP_SQ_E:        begin sq <= mres; sat <= sat | msat; end
        OP_ODD_INIT_X:  pw <= pos;
        OP_ODD_INIT_XT: pw <= xt;
        OP_EVEN_INIT:   pw <= sq;
        OP_ODD_MUL,
        OP_EVEN_MUL:    begin pw <= mres; sat <= sat | msat; end
        OP_ACC_A:       begin acc <= neg; sat <= sat | msat | nsat; end
        OP_ACC_AT:      begin at <= neg; sat <= sat | msat | nsat; end
        OP_XT,
        OP_VT,
        OP_NEWX,
        OP_NEWV,
        OP_VSQ:         begin tmp <= mres; sat <= sat | msat; end
        OP_XT_ADD:      begin xt <= ares; sat <= sat | asat; end
        OP_VT_ADD:      begin vt <= ares; sat <= sat | asat; end
        OP_NEWX_ADD:    begin pos <= ares; sat <= sat | asat; end
        OP_NEWV_ADD:    begin vel <= ares; sat <= sat | asat; end
        OP_PE:          begin pe <= mres; sat <= sat | msat; end
        OP_KE:          begin ke <= mres; sat <= sat | msat; end
        default:        ;
      endcase
      // Result capture into the output register.
      if (cmd.out_load) begin
        position_out <= pos;
        velocity_out <= vel;
        potential_energy <= pe[31] ? 31'd0 : pe[30:0];
        kinetic_energy <= ke[31] ? 31'd0 : ke[30:0];
        total_energy <= ares[31] ? 31'd0 : ares[30:0];
        overflow <= sat | asat;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/rk2_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rk2_controller: operation sequencer for the RK2 step
// Walks the micro-operation list of a load or step item and runs the
// output handshake.
// ----------------------------------------------------------------------------
module rk2_controller
  import rk2_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       operation,
  output logic            out_valid,
  input  wire logic       out_stall,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd
);

  ctrl_state_t state, state_next;
  dp_op_t      op, op_next;
  logic [2:0]  cnt, cnt_next;
  logic [2:0]  n;
  logic        valid_next;
  logic        acc_phase;

  assign n = (status.order == 3'd0) ? 3'd1 : status.order;
  assign in_stall = (state == ST_RUN) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op <= OP_NONE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op <= op_next;
      cnt <= cnt_next;
      out_valid <= valid_next;
    end
  end

  // Sequencing: each op names its successor; power loops count n-1 products.
  always_comb begin
    state_next = state;
    op_next = op;
    cnt_next = cnt;
    valid_next = out_valid && out_stall;
    cmd.op = OP_NONE;
    cmd.out_load = 1'b0;
    if (state == ST_RUN) begin
      cmd.op = op;
      cnt_next = 3'd1;
      unique case (op)
        OP_CLEAR:       op_next = OP_SQ_X;
        OP_LOAD:        op_next = OP_SQ_E;
        OP_SQ_X:        op_next = OP_ODD_INIT_X;
        OP_ODD_INIT_X,
        OP_ODD_INIT_XT: op_next = (n == 3'd1) ? ((op == OP_ODD_INIT_X) ? OP_ACC_A : OP_ACC_AT)
                                              : OP_ODD_MUL;
        OP_ODD_MUL: begin
          cnt_next = cnt + 3'd1;
          if (cnt_next == n) op_next = (acc_phase) ? OP_ACC_AT : OP_ACC_A;
        end
        OP_ACC_A:       op_next = OP_XT;
        OP_XT:          op_next = OP_XT_ADD;
        OP_XT_ADD:      op_next = OP_VT;
        OP_VT:          op_next = OP_VT_ADD;
        OP_VT_ADD:      op_next = OP_SQ_XT;
        OP_SQ_XT:       op_next = OP_ODD_INIT_XT;
        OP_ACC_AT:      op_next = OP_NEWX;
        OP_NEWX:        op_next = OP_NEWX_ADD;
        OP_NEWX_ADD:    op_next = OP_NEWV;
        OP_NEWV:        op_next = OP_NEWV_ADD;
        OP_NEWV_ADD:    op_next = OP_SQ_E;
        OP_SQ_E:        op_next = OP_EVEN_INIT;
        OP_EVEN_INIT:   op_next = (n == 3'd1) ? OP_PE : OP_EVEN_MUL;
        OP_EVEN_MUL: begin
          cnt_next = cnt + 3'd1;
          if (cnt_next == n) op_next = OP_PE;
        end
        OP_PE:          op_next = OP_VSQ;
        OP_VSQ:         op_next = OP_KE;
        OP_KE:          op_next = OP_TE;
        OP_TE: begin
          cmd.out_load = 1'b1;
          valid_next = 1'b1;
          state_next = ST_IDLE;
          op_next = OP_NONE;
        end
        default:        op_next = OP_NONE;
      endcase
    end else if (in_valid && !in_stall) begin
      // The load or the overflow clear happens while the payload is still valid.
      state_next = ST_RUN;
      op_next = operation ? OP_SQ_X : OP_SQ_E;
      cnt_next = 3'd1;
      cmd.op = operation ? OP_CLEAR : OP_LOAD;
    end
  end

  // Tracks which acceleration the odd power loop is feeding.
  always_ff @(posedge clk) begin
    if (rst) acc_phase <= 1'b0;
    else if (op == OP_SQ_X && state == ST_RUN) acc_phase <= 1'b0;
    else if (op == OP_SQ_XT && state == ST_RUN) acc_phase <= 1'b1;
  end

endmodule
`default_nettype wire

// ===== rtl/core/rk2_anharmonic_oscillator_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rk2_anharmonic_oscillator_step: midpoint Runge-Kutta oscillator step
// A step item runs the full operation list and a load item only its energy part;
// the power loops grow with power_order, where 0 is read as 1.
// One item at a time runs on the single shared multiplier; the next
// item is accepted as the result leaves, and a waiting result stalls
// the input.
// Reset clears position and velocity and sets the configuration registers to their reset values.
// ----------------------------------------------------------------------------
module rk2_anharmonic_oscillator_step
  import rk2_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        operation,
  input  wire logic [31:0] load_position,
  input  wire logic [31:0] load_velocity,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      position_out,
  output logic [31:0]      velocity_out,
  output logic [30:0]      potential_energy,
  output logic [30:0]      kinetic_energy,
  output logic [30:0]      total_energy,
  output logic             overflow,
  input  wire logic        cfg_write,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  logic [30:0] omega_sq, time_step, potential_coeff, half_mass;
  logic [2:0]  power_order;
  dp_cmd_t     cmd;
  dp_status_t  status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      omega_sq <= 31'd67108864;
      time_step <= 31'd167772;
      power_order <= 3'd7;
      potential_coeff <= 31'd4793490;
      half_mass <= 31'd8388608;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_OMEGA_SQ:  omega_sq <= cfg_data;
        REG_TIME_STEP: time_step <= cfg_data;
        REG_ORDER:     power_order <= cfg_data[2:0];
        REG_POT_COEFF: potential_coeff <= cfg_data;
        REG_HALF_MASS: half_mass <= cfg_data;
        default:       ;
      endcase
    end
  end

  assign status.order = power_order;

  rk2_controller u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .operation,
    .out_valid, .out_stall, .status, .cmd
  );

  rk2_datapath u_dp (
    .clk, .rst, .cmd, .load_position, .load_velocity,
    .omega_sq, .time_step, .potential_coeff, .half_mass,
    .position_out, .velocity_out, .potential_energy,
    .kinetic_energy, .total_energy, .overflow
  );

endmodule
`default_nettype wire
